// ----- design/assert_macros.svh -----
// Assertion macros shared by the play order cursor modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/poc_pkg.sv -----
// Types and constants of the play order cursor block.
// No dependencies; imported by every module of the block.
package poc_pkg;

	localparam int CNT_W = 11;
	localparam int IDX_W = 10;
	localparam int FUNC_W = 4;
	localparam int LCG_W = 32;
	localparam int DIV_CNT_W = $clog2(LCG_W);
	localparam int ADDR_W = 2;
	localparam int DATA_W = 32;

	localparam logic [LCG_W-1:0] LCG_MUL = 32'd1664525;
	localparam logic [LCG_W-1:0] LCG_ADD = 32'd1013904223;

	localparam logic [ADDR_W-1:0] ADDR_PLAY_MODE = 2'd0;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND  = 4'd0,
		FN_REMOVE  = 4'd1,
		FN_MOVE    = 4'd2,
		FN_SELECT  = 4'd3,
		FN_NEXT    = 4'd4,
		FN_PREV    = 4'd5,
		FN_ADVANCE = 4'd6,
		FN_CLEAR   = 4'd7,
		FN_QUERY   = 4'd8
	} func_e;

	typedef enum logic [1:0] {
		MODE_SEQ  = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_ALL  = 2'd2,
		MODE_SHUF = 2'd3
	} mode_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_JUMP,
		ST_EMIT
	} state_e;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CNT_W-1:0]  add_count;
		logic [IDX_W-1:0]  index_a;
		logic [IDX_W-1:0]  index_b;
	} cmd_t;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] entry_count;
		logic             cursor_valid;
		logic [IDX_W-1:0] cursor_index;
		logic             peek_next_valid;
		logic [IDX_W-1:0] peek_next_index;
		logic             peek_prev_valid;
		logic [IDX_W-1:0] peek_prev_index;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic lcg_step;
		logic div_step;
		logic jump;
		logic emit;
	} dp_ctl_t;

	typedef struct packed {
		logic need_shuf;
		logic div_last;
	} dp_sts_t;

endpackage

// ----- design/poc_ctrl.sv -----
// Sequencer of the play order cursor: command intake, shuffle steps, result hand-off.
// Depends on poc_pkg and assert_macros.svh; drives poc_dp through dp_ctl_t.
`include "assert_macros.svh"

module poc_ctrl import poc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  dp_sts_t sts,
	output dp_ctl_t ctl
);

	state_e state_q, state_d;
	logic   rsp_valid_q;
	logic   emit_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		emit_go = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d = sts.need_shuf ? ST_MUL : ST_EMIT;
			end
			ST_MUL: begin
				ctl.lcg_step = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_JUMP;
				end
			end
			ST_JUMP: begin
				ctl.jump = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					emit_go = 1'b1;
					ctl.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	`ASSERT_PROP(a_jump_after_div, clk, arst_n, (state_q == ST_JUMP) |-> ($past(state_q) == ST_DIV), "jump step not preceded by the division")
	`ASSERT_PROP(a_rsp_from_emit, clk, arst_n, $rose(rsp_valid_q) |-> ($past(state_q) == ST_EMIT), "response raised outside the emit step")

endmodule

// ----- design/poc_dp.sv -----
// Datapath of the play order cursor: list state, command evaluation, generator and divider.
// Depends on poc_pkg and assert_macros.svh; sequenced by poc_ctrl.
`include "assert_macros.svh"

module poc_dp import poc_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  mode_e   play_mode,
	input  cmd_t    cmd,
	input  dp_ctl_t ctl,
	output dp_sts_t sts,
	output rsp_t    rsp
);

	localparam int NW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(CAPACITY);
	localparam int WW = ((NW > CNT_W) ? NW : CNT_W) + 1;

	cmd_t              item_q;
	rsp_t              rsp_q;
	logic              ok_q;
	logic [NW-1:0]     total_q;
	logic [CW-1:0]     cursor_q;
	logic [LCG_W-1:0]  lcg_q;
	logic [LCG_W-1:0]  dvd_q;
	logic [NW-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [WW-1:0] n_w, c_w, a_w, b_w, add_w, cap_w, sum_w, dec_w;
	logic          nxt_v, prv_v;
	logic [CW-1:0] nxt_i, prv_i;
	logic [NW-1:0] new_total;
	logic [CW-1:0] new_cursor;
	logic          ex_ok, need_shuf;
	logic [LCG_W-1:0] lcg_next;
	logic [NW:0]   trial, divisor;
	logic [NW-1:0] rem_next;
	logic [NW:0]   off, jsum, jres;

	assign n_w   = WW'(total_q);
	assign c_w   = WW'(cursor_q);
	assign a_w   = WW'(item_q.index_a);
	assign b_w   = WW'(item_q.index_b);
	assign add_w = WW'(item_q.add_count);
	assign cap_w = WW'(CAPACITY);
	assign sum_w = n_w + add_w;
	assign dec_w = n_w - WW'(1);

	always_comb begin
		nxt_v = 1'b0;
		nxt_i = '0;
		prv_v = 1'b0;
		prv_i = '0;
		if (n_w != '0) begin
			if (play_mode == MODE_SHUF) begin
				if (n_w >= WW'(2)) begin
					nxt_v = 1'b1;
					nxt_i = (c_w + WW'(1) == n_w) ? '0 : CW'(c_w + WW'(1));
					prv_v = 1'b1;
					prv_i = (c_w == '0) ? CW'(dec_w) : CW'(c_w - WW'(1));
				end
			end else begin
				if (c_w + WW'(1) < n_w) begin
					nxt_v = 1'b1;
					nxt_i = CW'(c_w + WW'(1));
				end else if (play_mode == MODE_ALL && n_w > WW'(1)) begin
					nxt_v = 1'b1;
					nxt_i = '0;
				end
				if (c_w != '0) begin
					prv_v = 1'b1;
					prv_i = CW'(c_w - WW'(1));
				end else if (play_mode == MODE_ALL && n_w > WW'(1)) begin
					prv_v = 1'b1;
					prv_i = CW'(dec_w);
				end
			end
		end
	end

	always_comb begin
		new_total = total_q;
		new_cursor = cursor_q;
		ex_ok = 1'b0;
		need_shuf = 1'b0;
		case (item_q.func)
			FN_APPEND: begin
				if (sum_w <= cap_w) begin
					new_total = NW'(sum_w);
					ex_ok = 1'b1;
					if (n_w == '0) begin
						new_cursor = '0;
					end
				end
			end
			FN_REMOVE: begin
				if (a_w < n_w) begin
					new_total = NW'(dec_w);
					ex_ok = 1'b1;
					if (dec_w == '0) begin
						new_cursor = '0;
					end else if (a_w < c_w) begin
						new_cursor = CW'(c_w - WW'(1));
					end else if (c_w >= dec_w) begin
						new_cursor = CW'(dec_w - WW'(1));
					end
				end
			end
			FN_MOVE: begin
				if (a_w < n_w && b_w < n_w) begin
					ex_ok = 1'b1;
					if (c_w == a_w) begin
						new_cursor = CW'(b_w);
					end else if (a_w < c_w && c_w <= b_w) begin
						new_cursor = CW'(c_w - WW'(1));
					end else if (b_w <= c_w && c_w < a_w) begin
						new_cursor = CW'(c_w + WW'(1));
					end
				end
			end
			FN_SELECT: begin
				if (a_w < n_w) begin
					new_cursor = CW'(a_w);
					ex_ok = 1'b1;
				end
			end
			FN_NEXT, FN_PREV: begin
				if (play_mode == MODE_SHUF) begin
					need_shuf = (n_w >= WW'(2));
				end else if (item_q.func == FN_NEXT) begin
					if (nxt_v) begin
						new_cursor = nxt_i;
						ex_ok = 1'b1;
					end
				end else if (prv_v) begin
					new_cursor = prv_i;
					ex_ok = 1'b1;
				end
			end
			FN_ADVANCE: begin
				if (n_w != '0) begin
					if (play_mode == MODE_ONE) begin
						ex_ok = 1'b1;
					end else if (play_mode == MODE_SHUF) begin
						if (n_w == WW'(1)) begin
							ex_ok = 1'b1;
						end else begin
							need_shuf = 1'b1;
						end
					end else if (c_w + WW'(1) < n_w) begin
						new_cursor = CW'(c_w + WW'(1));
						ex_ok = 1'b1;
					end else if (play_mode == MODE_ALL) begin
						new_cursor = '0;
						ex_ok = 1'b1;
					end
				end
			end
			FN_CLEAR: begin
				new_total = '0;
				new_cursor = '0;
				ex_ok = 1'b1;
			end
			FN_QUERY: begin
				ex_ok = 1'b1;
			end
			default: begin
				ex_ok = 1'b0;
			end
		endcase
	end

	assign lcg_next = lcg_q * LCG_MUL + LCG_ADD;

	assign divisor = {1'b0, total_q} - (NW+1)'(1);
	assign trial = {rem_q, dvd_q[LCG_W-1]};
	assign rem_next = (trial >= divisor) ? NW'(trial - divisor) : NW'(trial);

	assign off  = {1'b0, rem_q} + (NW+1)'(1);
	assign jsum = (NW+1)'(cursor_q) + off;
	assign jres = (jsum >= {1'b0, total_q}) ? (jsum - {1'b0, total_q}) : jsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			cursor_q <= '0;
			lcg_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.exec) begin
				total_q <= new_total;
				cursor_q <= new_cursor;
			end
			if (ctl.lcg_step) begin
				lcg_q <= lcg_next;
				cnt_q <= '0;
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			if (ctl.jump) begin
				cursor_q <= CW'(jres);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
		if (ctl.exec) begin
			ok_q <= ex_ok;
		end else if (ctl.jump) begin
			ok_q <= 1'b1;
		end
		if (ctl.lcg_step) begin
			dvd_q <= lcg_next;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			dvd_q <= {dvd_q[LCG_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (ctl.emit) begin
			rsp_q.ok <= ok_q;
			rsp_q.entry_count <= CNT_W'(total_q);
			rsp_q.cursor_valid <= (total_q != '0);
			rsp_q.cursor_index <= (total_q != '0) ? IDX_W'(cursor_q) : '0;
			rsp_q.peek_next_valid <= nxt_v;
			rsp_q.peek_next_index <= IDX_W'(nxt_i);
			rsp_q.peek_prev_valid <= prv_v;
			rsp_q.peek_prev_index <= IDX_W'(prv_i);
		end
	end

	assign sts.need_shuf = need_shuf;
	assign sts.div_last = (cnt_q == DIV_CNT_W'(LCG_W - 1));
	assign rsp = rsp_q;

	`ASSERT_NEVER(a_empty_cursor_zero, clk, arst_n, (total_q == '0) && (cursor_q != '0), "cursor not zero on an empty list")
	`ASSERT_PROP(a_cursor_in_range, clk, arst_n, (total_q != '0) |-> (NW'(cursor_q) < total_q), "cursor beyond the last entry")
	`ASSERT_NEVER(a_total_capacity, clk, arst_n, n_w > cap_w, "entry count above capacity")

endmodule

// ----- design/play_order_cursor_top.sv -----
// Play order cursor: one command per transaction, one response each; the response is loaded
// after the execute step, or with a shuffle step after a 32x32 multiply step, 32 one-bit
// remainder steps and a jump step. One command is worked on at a time; the next is accepted
// the cycle after the response is loaded, and a stalled response holds the next one back
// in the emit step until the output register is taken.
// Asynchronous active-low reset clears entry count, cursor, shuffle state and play mode.
module play_order_cursor_top import poc_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	mode_e   play_mode_q;
	dp_ctl_t ctl;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q <= MODE_SEQ;
		end else if (psel && penable && pwrite && paddr == ADDR_PLAY_MODE) begin
			play_mode_q <= mode_e'(pwdata[1:0]);
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PLAY_MODE) ? DATA_W'(play_mode_q) : '0;

	poc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	poc_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.play_mode (play_mode_q),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
